// ----- hw/rtl/ttts_pkg.sv -----
// ----------------------------------------------------------------------------
// ttts_pkg
// Shared types, constants and tune tables of the tick timer / tone sequencer.
// ----------------------------------------------------------------------------
package ttts_pkg;

  localparam int unsigned FuncW      = 3;
  localparam int unsigned ArgW       = 16;
  localparam int unsigned RegW       = 16;
  localparam int unsigned TickW      = 32;
  localparam int unsigned NoteIdxW   = 4;
  localparam int unsigned TableLen   = 8;
  localparam int unsigned TableIdxW  = $clog2(TableLen);
  localparam int unsigned TuneNotes  = 8;

  localparam logic [RegW-1:0] GapTicksReset   = 16'd250;
  localparam logic [RegW-1:0] DelayScaleReset = 16'd100;
  localparam logic [RegW-1:0] IdlePeriod      = 16'd200;

  // result word: clock_ticks, delayed, buzzer_on, tone_period, tune_playing
  localparam int unsigned OutFieldW = TickW + 1 + 1 + RegW + 1;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // configuration register indexes
  localparam logic CfgGapTicks   = 1'b0;
  localparam logic CfgDelayScale = 1'b1;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 3'd0,
    FUNC_BUZZ  = 3'd1,
    FUNC_DELAY = 3'd2,
    FUNC_PAUSE = 3'd3,
    FUNC_TUNE1 = 3'd4,
    FUNC_TUNE2 = 3'd5
  } func_e;

  typedef struct packed {
    logic [RegW-1:0]     note_remaining;
    logic [RegW-1:0]     gap_remaining;
    logic                tune_active;
    logic [NoteIdxW-1:0] note_index;
    logic                second_tune;
    logic [RegW-1:0]     period;
    logic                buzz;
  } sound_state_t;

  localparam logic [RegW-1:0] LenOne [TableLen] =
    '{16'd500, 16'd15, 16'd15, 16'd500, 16'd70, 16'd150, 16'd20, 16'd100};
  localparam logic [RegW-1:0] PerOne [TableLen] =
    '{16'd2408, 16'd2273, 16'd2025, 16'd1911, 16'd1703, 16'd1517, 16'd1432, 16'd1276};
  localparam logic [RegW-1:0] LenTwo [TableLen] =
    '{16'd150, 16'd400, 16'd15, 16'd500, 16'd70, 16'd15, 16'd500, 16'd70};
  localparam logic [RegW-1:0] PerTwo [TableLen] =
    '{16'd500, 16'd2273, 16'd200, 16'd2408, 16'd2273, 16'd2025, 16'd2408, 16'd2273};

  function automatic logic [RegW-1:0] tune_len(logic sec, logic [TableIdxW-1:0] idx);
    return sec ? LenTwo[idx] : LenOne[idx];
  endfunction

  function automatic logic [RegW-1:0] tune_per(logic sec, logic [TableIdxW-1:0] idx);
    return sec ? PerTwo[idx] : PerOne[idx];
  endfunction

endpackage

// ----- hw/rtl/tick_timer_with_tone_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// tick_timer_with_tone_sequencer_core
// The result of an accepted transaction is registered and shows on m_axis in the next cycle.
// Throughput: one transaction per cycle; state updates in the accept cycle.
// The output register frees when taken, so input stalls only on output stall.
// Reset: asynchronous, active low; clears counters, restores register
// defaults (gap 250, delay scale 100) and idle tone period 200.
// ----------------------------------------------------------------------------
module tick_timer_with_tone_sequencer_core import ttts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ArgW-1:0]     s_axis_tdata,  // [15:0] arg
  input  logic [FuncW-1:0]    s_axis_tuser,  // [2:0] func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] clock_ticks, [32] delayed, [33] buzzer_on, [49:34] tone_period,
  // [50] tune_playing, [55:51] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [RegW-1:0]     cfg_wdata_i
);

  logic [RegW-1:0]     gap_ticks_q, delay_scale_q;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [RegW-1:0]     delay_q, delay_d;
  logic                pause_q, pause_d;
  sound_state_t        snd_q, snd_d, snd_tick;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                accept;
  logic [RegW-1:0]     delay_prod;
  func_e               func;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = func_e'(s_axis_tuser);
  // product wraps at 16 bits
  assign delay_prod    = s_axis_tdata * delay_scale_q;

  ttts_sound u_sound (
    .state_i     (snd_q),
    .gap_ticks_i (gap_ticks_q),
    .state_o     (snd_tick)
  );

  always_comb begin
    tick_d  = tick_q;
    delay_d = delay_q;
    pause_d = pause_q;
    snd_d   = snd_q;
    unique case (func)
      FUNC_TICK: begin
        // delay countdown swallows the tick
        if (delay_q != '0) begin
          delay_d = delay_q - 1'b1;
        end else if (!pause_q) begin
          tick_d = tick_q + 1'b1;
        end
        if (!pause_q) begin
          snd_d = snd_tick;
        end
      end
      FUNC_BUZZ: begin
        snd_d.note_remaining = s_axis_tdata;
      end
      FUNC_DELAY: begin
        delay_d = delay_prod;
      end
      FUNC_PAUSE: begin
        pause_d = !pause_q;
      end
      FUNC_TUNE1: begin
        snd_d.note_index  = '0;
        snd_d.tune_active = 1'b1;
      end
      FUNC_TUNE2: begin
        snd_d.second_tune = 1'b1;
        snd_d.note_index  = '0;
        snd_d.tune_active = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_d = '0;
    out_data_d[OutFieldW-1:0] = {snd_d.tune_active, snd_d.period, snd_d.buzz,
                                 (delay_d != '0), tick_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q   <= GapTicksReset;
      delay_scale_q <= DelayScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGapTicks:   gap_ticks_q   <= cfg_wdata_i;
        CfgDelayScale: delay_scale_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      delay_q <= '0;
      pause_q <= 1'b0;
      snd_q   <= '{note_remaining: '0, gap_remaining: '0, tune_active: 1'b0,
                   note_index: '0, second_tune: 1'b0, period: IdlePeriod,
                   buzz: 1'b0};
    end else if (accept) begin
      tick_q  <= tick_d;
      delay_q <= delay_d;
      pause_q <= pause_d;
      snd_q   <= snd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hw/rtl/ttts_sound.sv -----
// ----------------------------------------------------------------------------
// ttts_sound
// Next sound state for one unpaused tick: note countdown, gap, tune end, note fetch.
// ----------------------------------------------------------------------------
module ttts_sound import ttts_pkg::*; (
  input  sound_state_t    state_i,
  input  logic [RegW-1:0] gap_ticks_i,
  output sound_state_t    state_o
);

  logic at_end;

  assign at_end = (state_i.note_index >= NoteIdxW'(TuneNotes)) ||
                  (state_i.note_index >= NoteIdxW'(TableLen));

  always_comb begin
    state_o = state_i;
    if (state_i.note_remaining != '0) begin
      state_o.buzz           = 1'b1;
      state_o.note_remaining = state_i.note_remaining - 1'b1;
    end else if (!state_i.tune_active) begin
      state_o.buzz = 1'b0;
    end else if (state_i.gap_remaining != '0) begin
      state_o.gap_remaining = state_i.gap_remaining - 1'b1;
      state_o.buzz          = 1'b0;
    end else if (at_end) begin
      state_o.second_tune = 1'b0;
      state_o.tune_active = 1'b0;
      state_o.period      = IdlePeriod;
    end else begin
      // load next note, buzzer level stays as it was
      state_o.note_remaining = tune_len(state_i.second_tune,
                                        state_i.note_index[TableIdxW-1:0]);
      state_o.period         = tune_per(state_i.second_tune,
                                        state_i.note_index[TableIdxW-1:0]);
      state_o.note_index     = state_i.note_index + 1'b1;
      state_o.gap_remaining  = gap_ticks_i;
    end
  end

endmodule

// ----- hw/rtl/ttts_checker.sv -----
// ----------------------------------------------------------------------------
// ttts_checker
// Port-level checks of the tick timer / tone sequencer, bound to the core.
// ----------------------------------------------------------------------------
module ttts_checker import ttts_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned PerLo = TickW + 2;

  // input stalls only behind a stalled result
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without an output stall");

  // every accepted transaction yields a result next cycle
  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // with no tune running the period is always the idle value
  a_idle_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[OutFieldW-1] |->
      m_axis_tdata[PerLo +: RegW] == IdlePeriod)
    else $error("idle tone period not restored");

endmodule

bind tick_timer_with_tone_sequencer_core ttts_checker u_ttts_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tick timer / tone sequencer core. Commands go in
// on the s_axis stream and one status word comes back per transaction. A
// scoreboard class predicts each status word from its own copy of the timer,
// delay, pause and tune state, and checks the outputs field by field. Both
// stream sides idle and stall in random bursts, and the configuration
// registers are rewritten between phases.
// ----------------------------------------------------------------------------

import ttts_pkg::*;

// Reserved command codes: the block must leave its state alone.
localparam logic [FuncW-1:0] FuncSpareLo = 3'd6;
localparam logic [FuncW-1:0] FuncSpareHi = 3'd7;

localparam logic [15:0] TuneOneLen [8] = '{500, 15, 15, 500, 70, 150, 20, 100};
localparam logic [15:0] TuneOnePer [8] = '{2408, 2273, 2025, 1911, 1703, 1517, 1432, 1276};
localparam logic [15:0] TuneTwoLen [8] = '{150, 400, 15, 500, 70, 15, 500, 70};
localparam logic [15:0] TuneTwoPer [8] = '{500, 2273, 200, 2408, 2273, 2025, 2408, 2273};
localparam logic [3:0]  NotesPerTune   = 4'd8;
localparam logic [15:0] QuietPeriod    = 16'd200;

// Status word as it sits on m_axis_tdata, highest bits first.
typedef struct packed {
  logic [OutDataW-OutFieldW-1:0] pad;
  logic                          tune;
  logic [15:0]                   period;
  logic                          buzz;
  logic                          delayed;
  logic [31:0]                   ticks;
} tone_status_t;

class tone_timer_scoreboard;
  logic [15:0] gap_ticks;
  logic [15:0] delay_scale;

  logic [31:0] tick_count;
  logic [15:0] delay_count;
  bit          paused;
  logic [15:0] note_left;
  logic [15:0] gap_left;
  bit          tune_on;
  logic [3:0]  note_idx;
  bit          tune_two;
  logic [15:0] period;
  bit          buzz;

  tone_status_t status_q[$];
  int errors;
  int checked;
  int tunes_done;
  int cmd_count[8];

  function new();
    gap_ticks   = 16'd250;
    delay_scale = 16'd100;
    tick_count  = '0;
    delay_count = '0;
    paused      = 1'b0;
    note_left   = '0;
    gap_left    = '0;
    tune_on     = 1'b0;
    note_idx    = '0;
    tune_two    = 1'b0;
    period      = QuietPeriod;
    buzz        = 1'b0;
    errors      = 0;
    checked     = 0;
    tunes_done  = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
  endfunction

  function void set_reg(logic idx, logic [15:0] value);
    if (idx == CfgGapTicks) begin
      gap_ticks = value;
    end else begin
      delay_scale = value;
    end
  endfunction

  function int pending();
    return status_q.size();
  endfunction

  // Apply one accepted command and queue the status word it must produce.
  function void note_command(logic [FuncW-1:0] func, logic [15:0] arg);
    tone_status_t s;
    cmd_count[func]++;
    case (func)
      FUNC_TICK: begin
        if (delay_count != 0) begin
          delay_count--;
        end else if (!paused) begin
          tick_count++;
        end
        if (!paused) begin
          if (note_left != 0) begin
            buzz = 1'b1;
            note_left--;
          end else if (!tune_on) begin
            buzz = 1'b0;
          end else if (gap_left != 0) begin
            gap_left--;
            buzz = 1'b0;
          end else if (note_idx >= NotesPerTune) begin
            tune_two = 1'b0;
            tune_on  = 1'b0;
            period   = QuietPeriod;
            tunes_done++;
          end else begin
            // load next note; buzzer level holds for this tick
            note_left = tune_two ? TuneTwoLen[note_idx[2:0]] : TuneOneLen[note_idx[2:0]];
            period    = tune_two ? TuneTwoPer[note_idx[2:0]] : TuneOnePer[note_idx[2:0]];
            note_idx++;
            gap_left  = gap_ticks;
          end
        end
      end
      FUNC_BUZZ:  note_left = arg;
      FUNC_DELAY: delay_count = arg * delay_scale;
      FUNC_PAUSE: paused = !paused;
      FUNC_TUNE1: begin
        note_idx = '0;
        tune_on  = 1'b1;
      end
      FUNC_TUNE2: begin
        tune_two = 1'b1;
        note_idx = '0;
        tune_on  = 1'b1;
      end
      default: ;
    endcase
    s.pad     = '0;
    s.tune    = tune_on;
    s.period  = period;
    s.buzz    = buzz;
    s.delayed = (delay_count != 0);
    s.ticks   = tick_count;
    status_q.push_back(s);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 100) begin
      $display("MISMATCH %0t %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  task check_status(logic [OutDataW-1:0] word);
    tone_status_t got;
    tone_status_t want;
    got = tone_status_t'(word);
    if (status_q.size() == 0) begin
      report_mismatch("status word with nothing outstanding", got.ticks, 0);
    end else begin
      want = status_q.pop_front();
      checked++;
      if (got.ticks !== want.ticks) report_mismatch("clock_ticks", got.ticks, want.ticks);
      if (got.delayed !== want.delayed) report_mismatch("delayed", got.delayed, want.delayed);
      if (got.buzz !== want.buzz) report_mismatch("buzzer_on", got.buzz, want.buzz);
      if (got.period !== want.period) report_mismatch("tone_period", got.period, want.period);
      if (got.tune !== want.tune) report_mismatch("tune_playing", got.tune, want.tune);
      if (got.pad !== want.pad) report_mismatch("padding", got.pad, want.pad);
    end
  endtask
endclass

module testbench;

  localparam int StallLimit  = 1000;
  localparam int HoldOffLen  = 60;
  localparam int DrainLimit  = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ArgW-1:0]     s_axis_tdata;   // [15:0] arg
  logic [FuncW-1:0]    s_axis_tuser;   // [2:0] func
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [31:0] clock_ticks, [32] delayed, [33] buzzer_on, [49:34] tone_period,
  // [50] tune_playing, [55:51] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [RegW-1:0]     cfg_wdata_i;

  tone_timer_scoreboard sb;
  bit stall_on;
  bit hold_req;
  int quiet_cycles;

  tick_timer_with_tone_sequencer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: ready in random bursts, long hold-off on request.
  initial begin : sink_ready
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffLen - 1) @(negedge clk_i);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_status(m_axis_tdata);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("tb: failure");
        $finish;
      end
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(logic [FuncW-1:0] func, logic [15:0] arg);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= arg;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(func, arg);
  endtask

  // Drop valid and hold until every queued status word has come back.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Mostly ticks with short buzz/delay commands so tunes reach their end;
  // pause is toggled back quickly and tunes are rarely restarted mid-play.
  task automatic drive_random(int count, bit idle_on, int hold_at, int drain_at);
    int r;
    logic [FuncW-1:0] f;
    logic [15:0] a;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == drain_at) settle();
      r = $urandom_range(0, 99);
      a = 16'($urandom);
      if (sb.paused && r < 25) begin
        f = FUNC_PAUSE;
      end else if (r < 55) begin
        f = FUNC_TICK;
      end else if (r < 68) begin
        f = FUNC_BUZZ;
        if ($urandom_range(0, 7) != 0) a = 16'($urandom_range(0, 12));
      end else if (r < 76) begin
        f = FUNC_DELAY;
        if ($urandom_range(0, 7) != 0) a = 16'($urandom_range(0, 3));
      end else if (r < 80) begin
        f = FUNC_PAUSE;
      end else if (r < 92) begin
        if (sb.tune_on && r != 91) begin
          f = FUNC_TICK;
        end else begin
          f = $urandom_range(0, 1) ? FUNC_TUNE1 : FUNC_TUNE2;
        end
      end else if (r < 96) begin
        f = $urandom_range(0, 1) ? FuncSpareLo : FuncSpareHi;
      end else begin
        f = 3'($urandom_range(0, 7));
      end
      send_cmd(f, a);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic run_phase(logic [15:0] gap, logic [15:0] scale, int count, bit idle_on,
                           int hold_at, int drain_at);
    settle();
    write_reg(CfgGapTicks, gap);
    write_reg(CfgDelayScale, scale);
    stall_on = idle_on;
    drive_random(count, idle_on, hold_at, drain_at);
  endtask

  initial begin : main
    sb            = new();
    stall_on      = 1'b1;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgGapTicks;
    cfg_wdata_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset registers, field extremes, reserved codes, pause and tunes.
    send_cmd(FUNC_TICK, 16'h0000);
    send_cmd(FuncSpareLo, 16'hffff);
    send_cmd(FuncSpareHi, 16'h0000);
    send_cmd(FUNC_BUZZ, 16'hffff);
    send_cmd(FUNC_TICK, 16'hffff);
    send_cmd(FUNC_BUZZ, 16'h0000);
    send_cmd(FUNC_TICK, 16'h0000);
    send_cmd(FUNC_DELAY, 16'hffff);   // product wraps at 16 bits
    send_cmd(FUNC_TICK, 16'h0000);
    send_cmd(FUNC_PAUSE, 16'hffff);
    send_cmd(FUNC_TICK, 16'h0000);    // delay still counts while paused
    send_cmd(FUNC_DELAY, 16'h0000);
    send_cmd(FUNC_TICK, 16'h0000);    // frozen
    send_cmd(FUNC_PAUSE, 16'h0000);
    send_cmd(FUNC_TUNE2, 16'h0000);
    send_cmd(FUNC_TICK, 16'h0000);    // first note of tune two loads
    send_cmd(FUNC_TUNE1, 16'hffff);   // tune two stays selected
    send_cmd(FUNC_BUZZ, 16'h0001);    // cuts the running note
    send_cmd(FUNC_TICK, 16'h0000);
    send_cmd(FUNC_TICK, 16'h0000);
    send_cmd(FUNC_DELAY, 16'h0001);
    send_cmd(FUNC_TICK, 16'h0000);
    send_cmd(FUNC_TICK, 16'h0000);

    run_phase(16'd0,     16'd1,     250, 1'b1, -1, -1);
    run_phase(16'd2,     16'd7,     250, 1'b1, 120, -1);
    run_phase(16'hffff,  16'hffff,  150, 1'b1, -1, -1);
    run_phase(16'd1,     16'd0,     250, 1'b1, -1, 125);
    run_phase(16'd250,   16'd100,   300, 1'b0, -1, -1);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (int c = 0; c < DrainLimit && sb.pending() != 0; c++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report_mismatch("status words never returned", sb.pending(), 0);
    end

    $display("summary: %0d commands (%0d tick, %0d buzz, %0d delay, %0d pause, %0d tune)",
             sb.checked, sb.cmd_count[FUNC_TICK], sb.cmd_count[FUNC_BUZZ],
             sb.cmd_count[FUNC_DELAY], sb.cmd_count[FUNC_PAUSE],
             sb.cmd_count[FUNC_TUNE1] + sb.cmd_count[FUNC_TUNE2]);
    $display("summary: %0d reserved codes, %0d tunes ran to their end, %0d mismatches",
             sb.cmd_count[FuncSpareLo] + sb.cmd_count[FuncSpareHi], sb.tunes_done,
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- tick_timer_with_tone_sequencer_core.f -----
hw/rtl/ttts_pkg.sv
hw/rtl/ttts_sound.sv
hw/rtl/tick_timer_with_tone_sequencer_core.sv
hw/rtl/ttts_checker.sv
tb/testbench.sv
